/* hdl/clock_lock_gap_quality_rater_unit_defines.svh */
// Assertion macros used by the clock-lock gap quality rater controller.
`ifndef CLOCK_LOCK_GAP_QUALITY_RATER_UNIT_DEFINES_SVH
`define CLOCK_LOCK_GAP_QUALITY_RATER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define CLGQR_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define CLGQR_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* hdl/clgqr_pkg.sv */
// Package with types, constants and gap range tables of the quality rater.
package clgqr_pkg;

  localparam int TABLE_LEN      = 8;
  localparam int NUM_RANGES_DEF = 8;
  localparam int IDX_W          = 3;
  localparam int CNT_W          = 4;

  localparam int SERIAL_W   = 14;
  localparam int TIME_W     = 44;
  localparam int ERR_W      = 25;
  localparam int QUAL_W     = 7;
  localparam int TOL_W      = 16;
  localparam int GUARD_W    = 16;
  localparam int HIGH_W     = 33;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 25;

  localparam logic REQ_LOCK  = 1'b0;
  localparam logic REQ_CLOSE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_NOLOCK_ERR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACK_TOL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END_GUARD  = 2'd2;

  localparam logic [ERR_W-1:0]   NOLOCK_ERR_RST = 25'd20000000;
  localparam logic [TOL_W-1:0]   BACK_TOL_RST   = 16'd1500;
  localparam logic [GUARD_W-1:0] END_GUARD_RST  = 16'd100;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLASS,
    ST_EMIT,
    ST_JUMP
  } state_t;

  typedef enum logic [1:0] {
    CL_NONE,
    CL_JUMP,
    CL_EMIT
  } cls_t;

  typedef struct packed {
    logic             latch_in;
    logic             classify;
    logic             emit_seg;
    logic             emit_jump;
    logic             finish;
    logic             nolock;
    logic [IDX_W-1:0] seg_idx;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic seg_last;
    cls_t cls;
  } dp_sts_t;

  // Upper gap limit of each range in milliseconds.
  function automatic logic [HIGH_W-1:0] range_high(input logic [IDX_W-1:0] idx);
    logic [HIGH_W-1:0] v;
    case (idx)
      3'd0: v = 33'd4000000;
      3'd1: v = 33'd7200000;
      3'd2: v = 33'd14400000;
      3'd3: v = 33'd28800000;
      3'd4: v = 33'd86400000;
      3'd5: v = 33'd604800000;
      3'd6: v = 33'd2592000000;
      3'd7: v = 33'd7776000000;
    endcase
    return v;
  endfunction

  // Clock error of each range in microseconds.
  function automatic logic [ERR_W-1:0] range_err(input logic [IDX_W-1:0] idx);
    logic [ERR_W-1:0] v;
    case (idx)
      3'd0: v = 25'd1800;
      3'd1: v = 25'd3600;
      3'd2: v = 25'd7200;
      3'd3: v = 25'd14400;
      3'd4: v = 25'd43200;
      3'd5: v = 25'd302400;
      3'd6: v = 25'd1296000;
      3'd7: v = 25'd3888000;
    endcase
    return v;
  endfunction

  // Timing quality percent of each range.
  function automatic logic [QUAL_W-1:0] range_qual(input logic [IDX_W-1:0] idx);
    logic [QUAL_W-1:0] v;
    case (idx)
      3'd0: v = 7'd100;
      3'd1: v = 7'd80;
      3'd2: v = 7'd60;
      3'd3: v = 7'd40;
      3'd4: v = 7'd20;
      3'd5: v = 7'd10;
      3'd6: v = 7'd5;
      3'd7: v = 7'd5;
    endcase
    return v;
  endfunction

endpackage

/* hdl/clock_lock_gap_quality_rater_unit.sv */
// Clock-lock gap quality rater: splits lock gaps into timing-quality segments.
//
// Requests arrive on the in_ channel (valid/ready): a lock event (type 0) with a
// recorder serial and lock time, or an end-of-data closeout (type 1) with a time.
// Segments leave on the out_ channel (valid/ready), one per handshake, with
// out_last_of_run set on the final segment of a request. A backward jump past the
// tolerance gives one result with out_jump_error and out_last_of_run set, others zero.
// Registers are written through cfg_we/cfg_index/cfg_wdata; the user must write them
// only while the block is idle, as the block itself does not enforce this. A request
// is taken in ST_IDLE and classified in ST_CLASS; requests that give no result then
// free the block. Otherwise one segment leaves per cycle while the receiver accepts,
// up to nine (eight gap ranges and a no-lock segment), all from one segment-step unit.
// in_ready is high only between requests; a waiting result does not block intake.
// When the receiver stalls, the output register holds and segment stepping pauses.
// Synchronous active-low reset clears the tracking state and loads register defaults.
module clock_lock_gap_quality_rater_unit
  import clgqr_pkg::*;
#(
  parameter int NUM_RANGES = NUM_RANGES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_req_type,
  input  logic [SERIAL_W-1:0]   in_recorder_serial,
  input  logic [TIME_W-1:0]     in_event_time_ms,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SERIAL_W-1:0]   out_unit_serial,
  output logic [TIME_W-1:0]     out_seg_start_ms,
  output logic [TIME_W-1:0]     out_seg_end_ms,
  output logic [ERR_W-1:0]      out_clock_error_us,
  output logic [QUAL_W-1:0]     out_quality_percent,
  output logic                  out_jump_error,
  output logic                  out_last_of_run,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  clgqr_ctrl #(
    .NUM_RANGES(NUM_RANGES)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  clgqr_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_req_type        (in_req_type),
    .in_recorder_serial (in_recorder_serial),
    .in_event_time_ms   (in_event_time_ms),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_unit_serial    (out_unit_serial),
    .out_seg_start_ms   (out_seg_start_ms),
    .out_seg_end_ms     (out_seg_end_ms),
    .out_clock_error_us (out_clock_error_us),
    .out_quality_percent(out_quality_percent),
    .out_jump_error     (out_jump_error),
    .out_last_of_run    (out_last_of_run),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

endmodule

/* hdl/clgqr_dp.sv */
// Datapath: configuration, tracking state, request classification and result register.
module clgqr_dp
  import clgqr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctrl_cmd_t             cmd,
  output dp_sts_t               sts,
  input  logic                  in_req_type,
  input  logic [SERIAL_W-1:0]   in_recorder_serial,
  input  logic [TIME_W-1:0]     in_event_time_ms,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [SERIAL_W-1:0]   out_unit_serial,
  output logic [TIME_W-1:0]     out_seg_start_ms,
  output logic [TIME_W-1:0]     out_seg_end_ms,
  output logic [ERR_W-1:0]      out_clock_error_us,
  output logic [QUAL_W-1:0]     out_quality_percent,
  output logic                  out_jump_error,
  output logic                  out_last_of_run,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers.
  logic [ERR_W-1:0]   nolock_err_r;
  logic [TOL_W-1:0]   back_tol_r;
  logic [GUARD_W-1:0] end_guard_r;

  // Latched request.
  logic                req_r;
  logic [SERIAL_W-1:0] serial_in_r;
  logic [TIME_W-1:0]   time_r;

  // Tracking state.
  logic                started_r;
  logic [SERIAL_W-1:0] cur_serial_r;
  logic [TIME_W-1:0]   last_lock_r;
  logic [TIME_W-1:0]   last_end_r;

  // Values prepared during classification for the segment steps.
  logic [TIME_W-1:0]        gap_r;
  logic signed [TIME_W+1:0] time_guard_r;
  logic signed [TIME_W+1:0] lock_guard_r;

  // Result register.
  logic                out_valid_r;
  logic [SERIAL_W-1:0] out_serial_r;
  logic [TIME_W-1:0]   out_start_r;
  logic [TIME_W-1:0]   out_end_r;
  logic [ERR_W-1:0]    out_err_r;
  logic [QUAL_W-1:0]   out_qual_r;
  logic                out_jump_r;
  logic                out_last_r;

  logic                same_serial;
  logic [TIME_W:0]     fwd_diff;
  logic                backward;
  logic [TIME_W-1:0]   back_diff;
  logic                too_back;
  logic                far_gap;
  logic [TIME_W-1:0]   gap_cmb;
  cls_t                cls;

  logic [HIGH_W-1:0]        seg_high;
  logic                     beyond;
  logic [TIME_W-1:0]        seg_tend;
  logic signed [TIME_W+1:0] seg_end_g;
  logic [TIME_W-1:0]        seg_end_fl;
  logic [ERR_W-1:0]         seg_err;
  logic [QUAL_W-1:0]        seg_qual;

  // Classification of the latched request against the tracking state.
  always_comb begin
    same_serial = (serial_in_r == cur_serial_r);
    fwd_diff    = {1'b0, time_r} - {1'b0, last_lock_r};
    backward    = fwd_diff[TIME_W];
    back_diff   = last_lock_r - time_r;
    too_back    = back_diff > TIME_W'(back_tol_r);
    far_gap     = fwd_diff[TIME_W-1:0] > TIME_W'(range_high(IDX_W'(0)));
    gap_cmb     = backward ? '0 : fwd_diff[TIME_W-1:0];
    if (req_r == REQ_CLOSE) begin
      cls = started_r ? CL_EMIT : CL_NONE;
    end else if (!started_r) begin
      cls = CL_NONE;
    end else if (!same_serial) begin
      cls = CL_EMIT;
    end else if (backward) begin
      cls = too_back ? CL_JUMP : CL_NONE;
    end else begin
      cls = far_gap ? CL_EMIT : CL_NONE;
    end
  end

  // Segment end: range limit past last lock or event time; output end is less the guard.
  always_comb begin
    seg_high = range_high(cmd.seg_idx);
    beyond   = !cmd.nolock && (gap_r > TIME_W'(seg_high));
    if (beyond) begin
      seg_tend  = last_lock_r + TIME_W'(seg_high);
      seg_end_g = lock_guard_r + $signed({13'b0, seg_high});
    end else begin
      seg_tend  = time_r;
      seg_end_g = time_guard_r;
    end
    seg_end_fl = (seg_end_g > 0) ? seg_end_g[TIME_W-1:0] : '0;
    seg_err    = cmd.nolock ? nolock_err_r : range_err(cmd.seg_idx);
    seg_qual   = cmd.nolock ? '0 : range_qual(cmd.seg_idx);
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign sts.seg_last = !beyond;
  assign sts.cls      = cls;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nolock_err_r <= NOLOCK_ERR_RST;
      back_tol_r   <= BACK_TOL_RST;
      end_guard_r  <= END_GUARD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NOLOCK_ERR: nolock_err_r <= cfg_wdata[ERR_W-1:0];
        CFG_BACK_TOL:   back_tol_r   <= cfg_wdata[TOL_W-1:0];
        CFG_END_GUARD:  end_guard_r  <= cfg_wdata[GUARD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      req_r       <= in_req_type;
      serial_in_r <= in_recorder_serial;
      time_r      <= in_event_time_ms;
    end
    if (cmd.classify) begin
      gap_r        <= gap_cmb;
      time_guard_r <= $signed({2'b0, time_r}) - $signed({30'b0, end_guard_r});
      lock_guard_r <= $signed({2'b0, last_lock_r}) - $signed({30'b0, end_guard_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r    <= 1'b0;
      cur_serial_r <= '0;
      last_lock_r  <= '0;
      last_end_r   <= '0;
    end else begin
      if (cmd.classify && req_r == REQ_LOCK) begin
        if (!started_r) begin
          // The first lock seeds the state and causes no result.
          started_r    <= 1'b1;
          cur_serial_r <= serial_in_r;
          last_lock_r  <= time_r;
          last_end_r   <= time_r;
        end else if (same_serial && !backward && !far_gap) begin
          last_lock_r <= time_r;
        end
      end
      if (cmd.emit_seg) begin
        last_end_r <= seg_tend;
      end
      // The last segment ends at event time; lock moves lock/serial, close clears started.
      if (cmd.finish) begin
        if (req_r == REQ_CLOSE) begin
          started_r <= 1'b0;
        end else begin
          last_lock_r  <= time_r;
          cur_serial_r <= serial_in_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_seg || cmd.emit_jump) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_jump) begin
      out_serial_r <= '0;
      out_start_r  <= '0;
      out_end_r    <= '0;
      out_err_r    <= '0;
      out_qual_r   <= '0;
      out_jump_r   <= 1'b1;
      out_last_r   <= 1'b1;
    end else if (cmd.emit_seg) begin
      out_serial_r <= cur_serial_r;
      out_start_r  <= last_end_r;
      out_end_r    <= seg_end_fl;
      out_err_r    <= seg_err;
      out_qual_r   <= seg_qual;
      out_jump_r   <= 1'b0;
      out_last_r   <= !beyond;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_unit_serial     = out_serial_r;
  assign out_seg_start_ms    = out_start_r;
  assign out_seg_end_ms      = out_end_r;
  assign out_clock_error_us  = out_err_r;
  assign out_quality_percent = out_qual_r;
  assign out_jump_error      = out_jump_r;
  assign out_last_of_run     = out_last_r;

endmodule

/* hdl/clgqr_ctrl.sv */
// Controller: sequences request intake, classification and the segment steps.
`include "clock_lock_gap_quality_rater_unit_defines.svh"
module clgqr_ctrl
  import clgqr_pkg::*;
#(
  parameter int NUM_RANGES = NUM_RANGES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_sts_t   sts,
  output ctrl_cmd_t cmd
);

  // Ranges beyond the table length are not stepped through.
  localparam int RANGE_CNT = (NUM_RANGES > TABLE_LEN) ? TABLE_LEN : NUM_RANGES;

  state_t           state_r;
  state_t           state_nxt;
  logic [CNT_W-1:0] idx_r;
  logic [CNT_W-1:0] idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.seg_idx = idx_r[IDX_W-1:0];
    cmd.nolock  = (idx_r == CNT_W'(RANGE_CNT));
    unique case (state_r)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch_in = in_valid;
        if (in_valid) begin
          state_nxt = ST_CLASS;
        end
      end
      ST_CLASS: begin
        cmd.classify = 1'b1;
        idx_nxt      = '0;
        unique case (sts.cls)
          CL_JUMP: state_nxt = ST_JUMP;
          CL_EMIT: state_nxt = ST_EMIT;
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_seg = 1'b1;
          if (sts.seg_last) begin
            cmd.finish = 1'b1;
            state_nxt  = ST_IDLE;
          end else begin
            idx_nxt = idx_r + CNT_W'(1);
          end
        end
      end
      ST_JUMP: begin
        if (sts.out_free) begin
          cmd.emit_jump = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `CLGQR_ASSERT_NOW(a_emit_into_free_slot, cmd.emit_seg || cmd.emit_jump, sts.out_free)
  `CLGQR_ASSERT_NOW(a_step_within_count, state_r == ST_EMIT, idx_r <= CNT_W'(RANGE_CNT))
  `CLGQR_ASSERT_NEXT(a_quiet_request_returns, state_r == ST_CLASS && sts.cls == CL_NONE, state_r == ST_IDLE)
  `CLGQR_ASSERT_NOW(a_nolock_is_last, state_r == ST_EMIT && cmd.nolock, sts.seg_last)

endmodule
